@@ hw/rtl/cache_record_validator_macros.svh @@
// Assertion macros shared by the cache record validator RTL.
// Expects i_clk and i_rst_n in the scope of every module that uses them.
`ifndef CACHE_RECORD_VALIDATOR_MACROS_SVH
`define CACHE_RECORD_VALIDATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/crv_pkg.sv @@
// Types, constants and functions of the cache record validator.
// No dependencies; used by crv_parse and cache_record_validator.
package crv_pkg;

    localparam int OffW = 33;

    localparam logic [OffW-1:0] OffMax         = '1;
    localparam logic [OffW-1:0] MagicBytes     = 33'd8;
    localparam logic [OffW-1:0] OffFormatEnd   = 33'd11;
    localparam logic [OffW-1:0] OffHdrSizeEnd  = 33'd15;
    localparam logic [OffW-1:0] OffVendorEnd   = 33'd19;
    localparam logic [OffW-1:0] OffDeviceEnd   = 33'd23;
    localparam logic [OffW-1:0] OffDriverEnd   = 33'd27;
    localparam logic [OffW-1:0] OffBackendEnd  = 33'd31;
    localparam logic [OffW-1:0] OffUuidLoEnd   = 33'd39;
    localparam logic [OffW-1:0] OffUuidHiEnd   = 33'd47;
    localparam logic [OffW-1:0] OffManifestEnd = 33'd55;
    localparam logic [OffW-1:0] OffPayHashEnd  = 33'd63;
    localparam logic [OffW-1:0] OffPaySizeEnd  = 33'd67;
    localparam logic [OffW-1:0] HeaderBytes    = 33'd68;
    localparam logic [31:0]     HeaderSize     = 32'd68;

    typedef enum logic [3:0] {
        CfgVendor   = 4'd0,
        CfgDevice   = 4'd1,
        CfgDriver   = 4'd2,
        CfgBackend  = 4'd3,
        CfgUuidLow  = 4'd4,
        CfgUuidHigh = 4'd5,
        CfgManifest = 4'd6,
        CfgFormat   = 4'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        RsOk       = 3'd0,
        RsTrunc    = 3'd1,
        RsMagic    = 3'd2,
        RsFormat   = 3'd3,
        RsIdentity = 3'd4,
        RsSize     = 3'd5,
        RsHash     = 3'd6
    } t_reason;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_payload;
        logic       done_res;
        logic       accepted;
        logic [2:0] reject_reason;
    } t_out;

    typedef struct packed {
        logic [31:0] vendor_id;
        logic [31:0] device_id;
        logic [31:0] driver_version;
        logic [31:0] backend_version;
        logic [63:0] uuid_low;
        logic [63:0] uuid_high;
        logic [63:0] manifest_hash;
        logic [31:0] format_version;
    } t_cfg;

    // Everything the verdict needs about one byte, after its state update.
    typedef struct packed {
        logic [7:0]      data_byte;
        logic            is_payload;
        logic            last;
        logic            short_rec;
        logic            magic_bad;
        logic            format_bad;
        logic            identity_bad;
        logic [OffW-1:0] payload_len;
        logic [31:0]     declared_size;
        logic [63:0]     hash;
        logic [63:0]     declared_hash;
    } t_sum;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h4D;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h56;
            3'd3:    b = 8'h4B;
            3'd4:    b = 8'h50;
            3'd5:    b = 8'h31;
            3'd6:    b = 8'h33;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Multiplication by the FNV-64 prime, 2^40 + 2^8 + 0xB3, as shifts and adds.
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

@@ hw/rtl/crv_parse.sv @@
// Record state of the cache record validator: header parsing and payload hashing.
// Depends on crv_pkg and cache_record_validator_macros.svh.
`include "cache_record_validator_macros.svh"

module crv_parse #(
    parameter logic [63:0] HASH_SEED = 64'hCBF29CE484222325
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  crv_pkg::t_in  i_in,
    input  crv_pkg::t_cfg i_cfg,
    output crv_pkg::t_sum o_sum
);

    logic [crv_pkg::OffW-1:0] r_offset, n_offset;
    logic [63:0]              r_shift, n_shift;
    logic [63:0]              r_hash, n_hash;
    logic                     r_magic_bad, n_magic_bad;
    logic                     r_format_bad, n_format_bad;
    logic                     r_identity_bad, n_identity_bad;
    logic [31:0]              r_dsize, n_dsize;
    logic [63:0]              r_dhash, n_dhash;
    logic [31:0]              w32;
    logic                     is_pl;

    always_comb begin
        n_shift        = {i_in.data_byte, r_shift[63:8]};
        w32            = n_shift[63:32];
        is_pl          = r_offset >= crv_pkg::HeaderBytes;
        n_magic_bad    = r_magic_bad;
        n_format_bad   = r_format_bad;
        n_identity_bad = r_identity_bad;
        n_dsize        = r_dsize;
        n_dhash        = r_dhash;
        if (r_offset < crv_pkg::MagicBytes) begin
            if (i_in.data_byte != crv_pkg::magic_byte(r_offset[2:0])) begin
                n_magic_bad = 1'b1;
            end
        end
        unique case (r_offset)
            crv_pkg::OffFormatEnd: begin
                if (w32 != i_cfg.format_version) n_format_bad = 1'b1;
            end
            crv_pkg::OffHdrSizeEnd: begin
                if (w32 != crv_pkg::HeaderSize) n_format_bad = 1'b1;
            end
            crv_pkg::OffVendorEnd: begin
                if (w32 != i_cfg.vendor_id) n_identity_bad = 1'b1;
            end
            crv_pkg::OffDeviceEnd: begin
                if (w32 != i_cfg.device_id) n_identity_bad = 1'b1;
            end
            crv_pkg::OffDriverEnd: begin
                if (w32 != i_cfg.driver_version) n_identity_bad = 1'b1;
            end
            crv_pkg::OffBackendEnd: begin
                if (w32 != i_cfg.backend_version) n_identity_bad = 1'b1;
            end
            crv_pkg::OffUuidLoEnd: begin
                if (n_shift != i_cfg.uuid_low) n_identity_bad = 1'b1;
            end
            crv_pkg::OffUuidHiEnd: begin
                if (n_shift != i_cfg.uuid_high) n_identity_bad = 1'b1;
            end
            crv_pkg::OffManifestEnd: begin
                if (n_shift != i_cfg.manifest_hash) n_identity_bad = 1'b1;
            end
            crv_pkg::OffPayHashEnd: begin
                n_dhash = n_shift;
            end
            crv_pkg::OffPaySizeEnd: begin
                n_dsize = w32;
            end
            default: begin
            end
        endcase
        n_hash   = is_pl ? crv_pkg::fnv_mul(r_hash ^ {56'd0, i_in.data_byte}) : r_hash;
        n_offset = (r_offset == crv_pkg::OffMax) ? r_offset
                                                 : r_offset + crv_pkg::OffW'(1);
    end

    always_comb begin
        o_sum.data_byte     = i_in.data_byte;
        o_sum.is_payload    = is_pl;
        o_sum.last          = i_in.last_byte;
        o_sum.short_rec     = r_offset < crv_pkg::OffPaySizeEnd;
        o_sum.magic_bad     = n_magic_bad;
        o_sum.format_bad    = n_format_bad;
        o_sum.identity_bad  = n_identity_bad;
        o_sum.payload_len   = r_offset - crv_pkg::OffPaySizeEnd;
        o_sum.declared_size = n_dsize;
        o_sum.hash          = n_hash;
        o_sum.declared_hash = n_dhash;
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_shift <= n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset       <= '0;
            r_hash         <= HASH_SEED;
            r_magic_bad    <= 1'b0;
            r_format_bad   <= 1'b0;
            r_identity_bad <= 1'b0;
            r_dsize        <= '0;
            r_dhash        <= '0;
        end else if (i_take) begin
            if (i_in.last_byte) begin
                r_offset       <= '0;
                r_hash         <= HASH_SEED;
                r_magic_bad    <= 1'b0;
                r_format_bad   <= 1'b0;
                r_identity_bad <= 1'b0;
                r_dsize        <= '0;
                r_dhash        <= '0;
            end else begin
                r_offset       <= n_offset;
                r_hash         <= n_hash;
                r_magic_bad    <= n_magic_bad;
                r_format_bad   <= n_format_bad;
                r_identity_bad <= n_identity_bad;
                r_dsize        <= n_dsize;
                r_dhash        <= n_dhash;
            end
        end
    end

    `CRV_ASSERT_NEXT(a_offset_restart, i_take && i_in.last_byte, r_offset == '0 && r_hash == HASH_SEED, "Record state not cleared after the last byte.")
    `CRV_ASSERT_NEXT(a_offset_step, i_take && !i_in.last_byte && (r_offset != crv_pkg::OffMax), r_offset == $past(r_offset) + crv_pkg::OffW'(1), "Byte offset did not advance by one.")
    `CRV_ASSERT_NEXT(a_magic_hold, i_take && !i_in.last_byte && r_magic_bad, r_magic_bad, "Magic failure lost within a file.")

endmodule

@@ hw/rtl/cache_record_validator.sv @@
// Top level of the cache record validator: configuration registers, verdict stage
// and output register. Depends on crv_pkg, crv_parse and cache_record_validator_macros.svh.
//
// The block checks a cache file that arrives one byte per transaction, passes
// every byte through and gives the verdict with the byte marked last. It takes
// one byte in every clock cycle while the output side does not stall; the limit
// is the FNV-1a step on the running hash, which is updated once per accepted
// byte. The edge that accepts a byte stores its parsed state; the verdict is
// registered in the output register once that register is free. Configuration
// writes are always taken and must only be made while no file is in flight.
`include "cache_record_validator_macros.svh"

module cache_record_validator #(
    parameter logic [63:0] HASH_SEED = 64'hCBF29CE484222325
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  crv_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output crv_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [3:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data
);

    crv_pkg::t_cfg r_cfg;
    crv_pkg::t_sum sum;
    crv_pkg::t_sum r_s1;
    logic          r_s1_valid;
    crv_pkg::t_out r_out, n_out;
    logic          r_o_valid;
    logic          s2_ready;
    logic          in_fire;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                crv_pkg::CfgVendor:   r_cfg.vendor_id       <= i_cfg_data[31:0];
                crv_pkg::CfgDevice:   r_cfg.device_id       <= i_cfg_data[31:0];
                crv_pkg::CfgDriver:   r_cfg.driver_version  <= i_cfg_data[31:0];
                crv_pkg::CfgBackend:  r_cfg.backend_version <= i_cfg_data[31:0];
                crv_pkg::CfgUuidLow:  r_cfg.uuid_low        <= i_cfg_data;
                crv_pkg::CfgUuidHigh: r_cfg.uuid_high       <= i_cfg_data;
                crv_pkg::CfgManifest: r_cfg.manifest_hash   <= i_cfg_data;
                crv_pkg::CfgFormat:   r_cfg.format_version  <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign s2_ready   = !r_o_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s2_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    crv_parse #(
        .HASH_SEED (HASH_SEED)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_fire),
        .i_in    (i_in_data),
        .i_cfg   (r_cfg),
        .o_sum   (sum)
    );

    always_comb begin
        crv_pkg::t_reason reason;
        reason = crv_pkg::RsOk;
        if (r_s1.last) begin
            if (r_s1.short_rec) begin
                reason = crv_pkg::RsTrunc;
            end else if (r_s1.magic_bad) begin
                reason = crv_pkg::RsMagic;
            end else if (r_s1.format_bad) begin
                reason = crv_pkg::RsFormat;
            end else if (r_s1.identity_bad) begin
                reason = crv_pkg::RsIdentity;
            end else if (r_s1.payload_len != {1'b0, r_s1.declared_size}) begin
                reason = crv_pkg::RsSize;
            end else if (r_s1.hash != r_s1.declared_hash) begin
                reason = crv_pkg::RsHash;
            end
        end
        n_out.payload_byte  = r_s1.data_byte;
        n_out.is_payload    = r_s1.is_payload;
        n_out.done_res      = r_s1.last;
        n_out.accepted      = r_s1.last && (reason == crv_pkg::RsOk);
        n_out.reject_reason = reason;
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= sum;
        end
        if (s2_ready && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s2_ready) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_ready) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

    `CRV_ASSERT_NOW(a_accept_done, r_o_valid && r_out.accepted, r_out.done_res && (r_out.reject_reason == crv_pkg::RsOk), "Acceptance given without a clean verdict.")
    `CRV_ASSERT_NOW(a_no_verdict, r_o_valid && !r_out.done_res, !r_out.accepted && (r_out.reject_reason == crv_pkg::RsOk), "Verdict given on a byte that is not the last.")
    `CRV_ASSERT_NEXT(a_s1_held, r_s1_valid && !s2_ready, r_s1_valid, "Parsed transaction lost while the output stalled.")
    `CRV_ASSERT_NEXT(a_short_rec, r_s1_valid && s2_ready && r_s1.last && r_s1.short_rec, r_o_valid && (r_out.reject_reason == crv_pkg::RsTrunc), "Short file not reported as truncated.")

endmodule

@@ verif/crv_checker.sv @@
`timescale 1ns / 100ps
// Transaction checker for the cache record validator: watches the byte, result and
// register channels, predicts each result and compares it field by field.
// Depends on crv_pkg.
module crv_checker #(
    parameter logic [63:0] HASH_SEED = 64'hCBF29CE484222325
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  crv_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  crv_pkg::t_out i_out_data,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [3:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    output int            o_fail_count,
    output int            o_pending
);

    localparam logic [63:0] FnvPrime       = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] MagicWord      = 64'h0033_3150_4B56_504D;
    localparam logic [32:0] OffsetSat      = '1;
    localparam logic [32:0] LastHeaderByte = 33'd67;
    localparam logic [32:0] HeaderLen      = 33'd68;

    crv_pkg::t_cfg regs;
    logic [32:0]   rec_offset;
    logic [63:0]   rec_shift;
    logic [63:0]   run_hash;
    logic [63:0]   declared_hash;
    logic [31:0]   declared_size;
    logic          bad_magic;
    logic          bad_format;
    logic          bad_identity;
    crv_pkg::t_out outbound_q[$];
    int            fail_n = 0;

    function automatic void clear_record();
        rec_offset    = '0;
        rec_shift     = '0;
        run_hash      = HASH_SEED;
        declared_hash = '0;
        declared_size = '0;
        bad_magic     = 1'b0;
        bad_format    = 1'b0;
        bad_identity  = 1'b0;
    endfunction

    function automatic crv_pkg::t_out step_record(input crv_pkg::t_in item);
        logic [32:0]      off;
        logic [63:0]      w64;
        logic [31:0]      w32;
        logic [7:0]       b;
        crv_pkg::t_reason why;
        crv_pkg::t_out    res;
        b         = item.data_byte;
        off       = rec_offset;
        rec_shift = {b, rec_shift[63:8]};
        w64       = rec_shift;
        w32       = rec_shift[63:32];
        if (off < 33'd8) begin
            if (b != MagicWord[off[2:0] * 8 +: 8]) bad_magic = 1'b1;
        end else begin
            case (off)
                33'd11: bad_format |= (w32 != regs.format_version);
                33'd15: bad_format |= (w32 != 32'd68);
                33'd19: bad_identity |= (w32 != regs.vendor_id);
                33'd23: bad_identity |= (w32 != regs.device_id);
                33'd27: bad_identity |= (w32 != regs.driver_version);
                33'd31: bad_identity |= (w32 != regs.backend_version);
                33'd39: bad_identity |= (w64 != regs.uuid_low);
                33'd47: bad_identity |= (w64 != regs.uuid_high);
                33'd55: bad_identity |= (w64 != regs.manifest_hash);
                33'd63: declared_hash = w64;
                33'd67: declared_size = w32;
                default: ;
            endcase
        end
        if (off >= HeaderLen) run_hash = (run_hash ^ {56'd0, b}) * FnvPrime;
        why = crv_pkg::RsOk;
        if (item.last_byte) begin
            if (off < LastHeaderByte) why = crv_pkg::RsTrunc;
            else if (bad_magic) why = crv_pkg::RsMagic;
            else if (bad_format) why = crv_pkg::RsFormat;
            else if (bad_identity) why = crv_pkg::RsIdentity;
            else if ((off - LastHeaderByte) != {1'b0, declared_size}) why = crv_pkg::RsSize;
            else if (run_hash != declared_hash) why = crv_pkg::RsHash;
        end
        res.payload_byte  = b;
        res.is_payload    = (off >= HeaderLen);
        res.done_res      = item.last_byte;
        res.accepted      = item.last_byte && (why == crv_pkg::RsOk);
        res.reject_reason = why;
        if (item.last_byte) clear_record();
        else if (off != OffsetSat) rec_offset = off + 33'd1;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_n++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        crv_pkg::t_out want;
        if (!i_rst_n) begin
            regs = '0;
            clear_record();
            outbound_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    crv_pkg::CfgVendor:   regs.vendor_id       = i_cfg_data[31:0];
                    crv_pkg::CfgDevice:   regs.device_id       = i_cfg_data[31:0];
                    crv_pkg::CfgDriver:   regs.driver_version  = i_cfg_data[31:0];
                    crv_pkg::CfgBackend:  regs.backend_version = i_cfg_data[31:0];
                    crv_pkg::CfgUuidLow:  regs.uuid_low        = i_cfg_data;
                    crv_pkg::CfgUuidHigh: regs.uuid_high       = i_cfg_data;
                    crv_pkg::CfgManifest: regs.manifest_hash   = i_cfg_data;
                    crv_pkg::CfgFormat:   regs.format_version  = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) outbound_q = {outbound_q, step_record(i_in_data)};
            if (i_out_valid && i_out_ready) begin
                if (outbound_q.size() == 0) begin
                    $error("result transaction with no byte outstanding: %0h", i_out_data);
                    fail_n++;
                end else begin
                    want = outbound_q.pop_front();
                    check_field("payload_byte", want.payload_byte, i_out_data.payload_byte);
                    check_field("is_payload", want.is_payload, i_out_data.is_payload);
                    check_field("done_res", want.done_res, i_out_data.done_res);
                    check_field("accepted", want.accepted, i_out_data.accepted);
                    check_field("reject_reason", want.reject_reason,
                                i_out_data.reject_reason);
                end
            end
        end
        o_pending    <= outbound_q.size();
        o_fail_count <= fail_n;
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Top level of the cache record validator testbench: clock, reset, byte stream,
// register writes and verdict. Depends on crv_pkg, crv_checker and the block itself.
module tb_top;

    localparam int          CycleLimit  = 1_000_000;
    localparam int          TargetBytes = 960;
    localparam int          Phases      = 4;
    localparam logic [63:0] HashSeed    = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FnvPrime    = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] MagicWord   = 64'h0033_3150_4B56_504D;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    crv_pkg::t_in  in_data;
    logic          out_valid;
    logic          out_ready;
    crv_pkg::t_out out_data;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [3:0]    cfg_index;
    logic [63:0]   cfg_data;
    int            fail_count;
    int            pending;
    int            cycles = 0;
    int            sent = 0;
    bit            tx_quiet;
    crv_pkg::t_cfg cfg_now = '0;
    logic [7:0]    file_q[$];

    cache_record_validator #(.HASH_SEED(HashSeed)) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    crv_checker #(.HASH_SEED(HashSeed)) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int idle_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] flip_if(input bit cond, input int width);
        return cond ? (64'd1 << $urandom_range(0, width - 1)) : 64'd0;
    endfunction

    task automatic put_le(input logic [63:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++) file_q = {file_q, value[8 * i +: 8]};
    endtask

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int           gap;
        crv_pkg::t_in item;
        gap = idle_len(tx_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.data_byte = value;
        item.last_byte = is_last;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_record(input int body_len, input logic [5:0] faults,
                               input int cut_len);
        logic [7:0]  body[$];
        logic [63:0] digest;
        logic [7:0]  b;
        int          victim;
        int          len;
        digest = HashSeed;
        for (int i = 0; i < body_len; i++) begin
            b = 8'($urandom);
            body = {body, b};
            digest = (digest ^ {56'd0, b}) * FnvPrime;
        end
        victim = faults[3] ? $urandom_range(0, 6) : 7;
        file_q.delete();
        put_le(MagicWord ^ flip_if(faults[0], 64), 8);
        put_le(cfg_now.format_version ^ flip_if(faults[1], 32), 4);
        put_le(32'd68 ^ flip_if(faults[2], 32), 4);
        put_le(cfg_now.vendor_id ^ flip_if(victim == 0, 32), 4);
        put_le(cfg_now.device_id ^ flip_if(victim == 1, 32), 4);
        put_le(cfg_now.driver_version ^ flip_if(victim == 2, 32), 4);
        put_le(cfg_now.backend_version ^ flip_if(victim == 3, 32), 4);
        put_le(cfg_now.uuid_low ^ flip_if(victim == 4, 64), 8);
        put_le(cfg_now.uuid_high ^ flip_if(victim == 5, 64), 8);
        put_le(cfg_now.manifest_hash ^ flip_if(victim == 6, 64), 8);
        put_le(digest ^ flip_if(faults[5], 64), 8);
        put_le(64'(body_len) ^ flip_if(faults[4], 32), 4);
        foreach (body[i]) file_q = {file_q, body[i]};
        len = (cut_len > 0) ? cut_len : file_q.size();
        tx_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) send_byte(file_q[i], i == len - 1);
    endtask

    task automatic write_reg(input logic [3:0] index, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic load_config(input crv_pkg::t_cfg setting);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        write_reg(crv_pkg::CfgVendor, {$urandom, setting.vendor_id});
        write_reg(crv_pkg::CfgDevice, {$urandom, setting.device_id});
        write_reg(crv_pkg::CfgDriver, {$urandom, setting.driver_version});
        write_reg(crv_pkg::CfgBackend, {$urandom, setting.backend_version});
        write_reg(4'($urandom_range(int'(crv_pkg::CfgFormat) + 1, 15)), {$urandom, $urandom});
        write_reg(crv_pkg::CfgUuidLow, setting.uuid_low);
        write_reg(crv_pkg::CfgUuidHigh, setting.uuid_high);
        write_reg(crv_pkg::CfgManifest, setting.manifest_hash);
        write_reg(crv_pkg::CfgFormat, {$urandom, setting.format_version});
        cfg_valid <= 1'b0;
        cfg_now = setting;
    endtask

    initial begin : rx_side
        int stall;
        bit quiet;
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            quiet = ($urandom_range(0, 7) == 0);
            stall = idle_len(quiet);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat (quiet ? $urandom_range(40, 120) : $urandom_range(1, 12)) @(negedge clk);
        end
    end

    initial begin : tx_side
        crv_pkg::t_cfg setting;
        int            goal;
        int            r;
        int            body_len;
        int            cut;
        logic [5:0]    faults;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        tx_quiet  = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // One-byte files, a header one byte short, then an empty and a fully broken record.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_record(0, 6'd0, 67);
        send_record(0, 6'd0, 0);
        send_record(1, 6'h3F, 0);

        for (int ph = 0; ph < Phases; ph++) begin
            if (ph > 0) begin
                if (ph == 1) begin
                    setting = '1;
                end else begin
                    for (int k = 0; k < 11; k++) setting[32 * k +: 32] = $urandom;
                end
                in_valid <= 1'b0;
                load_config(setting);
            end
            goal = sent + TargetBytes / Phases;
            while (sent < goal) begin
                r = $urandom_range(0, 99);
                if (r < 80) body_len = $urandom_range(0, 12);
                else if (r < 98) body_len = $urandom_range(13, 40);
                else body_len = $urandom_range(150, 300);
                r = $urandom_range(0, 99);
                if (r < 50) faults = 6'd0;
                else if (r < 85) faults = 6'd1 << $urandom_range(0, 5);
                else faults = 6'($urandom_range(1, 63));
                r = $urandom_range(0, 99);
                cut = 0;
                if (r < 12) cut = $urandom_range(1, 67);
                else if (r < 18 && body_len > 0) cut = 68 + $urandom_range(0, body_len - 1);
                send_record(body_len, faults, cut);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
